// ===== rtl/core/qes_pkg.sv =====
// Shared types and constants of the quadratic equation solver.
// No dependencies.
package qes_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;
    localparam int ROOT_FRAC  = 16;

    typedef enum logic [2:0] {
        ST_INFINITE = 3'd0,
        ST_NONE     = 3'd1,
        ST_LINEAR   = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_TWO      = 3'd4
    } t_status;

    typedef struct packed {
        t_status status;
        logic    neg;
    } t_ctl;

endpackage

// ===== rtl/core/qes_if.sv =====
// Request channels of the solver: coefficient triples in, roots out.
// Depends on nothing.
interface qes_coef_if #(parameter int CW = 16);
    logic          valid;
    logic          ready;
    logic [CW-1:0] coef_a;
    logic [CW-1:0] coef_b;
    logic [CW-1:0] coef_c;
    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qes_root_if #(parameter int RW = 32);
    logic          valid;
    logic          ready;
    logic [2:0]    root_status;
    logic [RW-1:0] root_one;
    logic [RW-1:0] root_two;
    logic          saturated;
    modport source (output valid, root_status, root_one, root_two, saturated, input ready);
    modport sink (input valid, root_status, root_one, root_two, saturated, output ready);
endinterface

// ===== rtl/core/quadratic_equation_solver_core.sv =====
// Quadratic equation solver top: discriminant, square root, two divider lanes, clipping.
// Depends on qes_pkg, qes_if, qes_disc, qes_sqrt, qes_div.
// Accepts one Q8.8 coefficient triple per cycle while no result waits at the output, and
// returns one status with up to two Q16.16 roots per request. A request passes through
// the discriminant, the one-bit-per-stage square root and divider pipelines, and the
// output register. The whole pipeline holds while a result waits at the output.
module quadratic_equation_solver_core #(
    parameter int COEF_WIDTH = qes_pkg::COEF_WIDTH,
    parameter int ROOT_WIDTH = qes_pkg::ROOT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qes_coef_if.sink   i_coef,
    qes_root_if.source o_root
);
    localparam int CW   = COEF_WIDTH;
    localparam int RW   = ROOT_WIDTH;
    localparam int FR   = qes_pkg::ROOT_FRAC;
    localparam int SW   = CW+1;
    localparam int NW   = CW+2;
    localparam int DSW  = CW+1;
    localparam int MW   = CW+1+FR;
    localparam int EW   = (MW+1 > RW) ? MW+1 : RW;
    localparam int SB1  = 3*CW+2;
    localparam int CTLW = $bits(qes_pkg::t_ctl);

    localparam logic signed [EW:0] HI = {{(EW+2-RW){1'b0}}, {(RW-1){1'b1}}};
    localparam logic signed [EW:0] LO = ~HI;

    logic en;
    logic r_ov;
    assign en = !r_ov || o_root.ready;
    assign i_coef.ready = en;

    logic            d_v, d_neg, d_zero;
    logic [2*SW-1:0] d_x;
    logic [CW-1:0]   d_a, d_b, d_c;

    qes_disc #(.CW(CW)) u_disc (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(i_coef.valid),
        .i_a(i_coef.coef_a), .i_b(i_coef.coef_b), .i_c(i_coef.coef_c),
        .o_valid(d_v), .o_d(d_x), .o_a(d_a), .o_b(d_b), .o_c(d_c),
        .o_dneg(d_neg), .o_dzero(d_zero)
    );

    logic           s_v;
    logic [SW-1:0]  s_root;
    logic [SB1-1:0] s_sb;

    qes_sqrt #(.SW(SW), .SBW(SB1)) u_sqrt (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_v), .i_x(d_x),
        .i_sb({d_a, d_b, d_c, d_neg, d_zero}),
        .o_valid(s_v), .o_root(s_root), .o_sb(s_sb)
    );

    // operand setup
    logic [CW-1:0]    p_a, p_b, p_c;
    logic             p_neg, p_zero;
    logic signed [NW-1:0] nb, nc, sx, num1, num2, den;
    logic signed [NW-1:0] absd, abs1, abs2;
    qes_pkg::t_ctl    n_ctl;
    logic             n_neg2, dneg;
    logic [NW-2:0]    mag1, mag2, magd;

    assign {p_a, p_b, p_c, p_neg, p_zero} = s_sb;

    always_comb begin
        nb = -$signed({{2{p_b[CW-1]}}, p_b});
        nc = -$signed({{2{p_c[CW-1]}}, p_c});
        sx = $signed({1'b0, s_root});
        num2 = nb - sx;
        if (p_a == '0) begin
            den  = $signed({{2{p_b[CW-1]}}, p_b});
            num1 = nc;
            if (p_b != '0) begin
                n_ctl.status = qes_pkg::ST_LINEAR;
            end else if (p_c == '0) begin
                n_ctl.status = qes_pkg::ST_INFINITE;
            end else begin
                n_ctl.status = qes_pkg::ST_NONE;
            end
        end else begin
            den = $signed({p_a[CW-1], p_a, 1'b0});
            if (p_neg) begin
                n_ctl.status = qes_pkg::ST_NONE;
                num1 = nb;
            end else if (p_zero) begin
                n_ctl.status = qes_pkg::ST_DOUBLE;
                num1 = nb;
            end else begin
                n_ctl.status = qes_pkg::ST_TWO;
                num1 = nb + sx;
            end
        end
        dneg  = den[NW-1];
        absd  = dneg ? -den : den;
        abs1  = num1[NW-1] ? -num1 : num1;
        abs2  = num2[NW-1] ? -num2 : num2;
        magd  = absd[NW-2:0];
        mag1  = abs1[NW-2:0];
        mag2  = abs2[NW-2:0];
        n_ctl.neg = num1[NW-1] ^ dneg;
        n_neg2    = num2[NW-1] ^ dneg;
    end

    logic             r_pv;
    logic [MW-1:0]    r_dvd1, r_dvd2;
    logic [DSW-1:0]   r_dvs;
    qes_pkg::t_ctl    r_ctl;
    logic             r_neg2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= s_v;
        end
        if (en) begin
            r_dvd1 <= {mag1, {FR{1'b0}}};
            r_dvd2 <= {mag2, {FR{1'b0}}};
            r_dvs  <= magd;
            r_ctl  <= n_ctl;
            r_neg2 <= n_neg2;
        end
    end

    logic            q1_v, q2_v, q2_neg;
    logic [MW-1:0]   q1, q2;
    logic [CTLW-1:0] q1_sb;
    qes_pkg::t_ctl   q_ctl;

    qes_div #(.DVW(MW), .DSW(DSW), .SBW(CTLW)) u_div_one (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_pv), .i_dvd(r_dvd1), .i_dvs(r_dvs),
        .i_sb(r_ctl), .o_valid(q1_v), .o_quot(q1), .o_sb(q1_sb)
    );

    qes_div #(.DVW(MW), .DSW(DSW), .SBW(1)) u_div_two (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_pv), .i_dvd(r_dvd2), .i_dvs(r_dvs),
        .i_sb(r_neg2), .o_valid(q2_v), .o_quot(q2), .o_sb(q2_neg)
    );

    assign q_ctl = qes_pkg::t_ctl'(q1_sb);

    // sign, clip and select
    logic signed [EW:0] v1, v2;
    logic [RW-1:0]      c1, c2;
    logic               k1, k2, use1, use2;

    always_comb begin
        v1 = $signed({{(EW+1-MW){1'b0}}, q1});
        v2 = $signed({{(EW+1-MW){1'b0}}, q2});
        if (q_ctl.neg) v1 = -v1;
        if (q2_neg)    v2 = -v2;
        k1 = (v1 > HI) || (v1 < LO);
        k2 = (v2 > HI) || (v2 < LO);
        c1 = (v1 > HI) ? HI[RW-1:0] : (v1 < LO) ? LO[RW-1:0] : v1[RW-1:0];
        c2 = (v2 > HI) ? HI[RW-1:0] : (v2 < LO) ? LO[RW-1:0] : v2[RW-1:0];
        use2 = (q_ctl.status == qes_pkg::ST_TWO);
        use1 = use2 || (q_ctl.status == qes_pkg::ST_LINEAR)
                    || (q_ctl.status == qes_pkg::ST_DOUBLE);
    end

    logic [2:0]    r_status;
    logic [RW-1:0] r_r1, r_r2;
    logic          r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= q1_v && q2_v;
        end
        if (en) begin
            r_status <= q_ctl.status;
            r_r1     <= use1 ? c1 : '0;
            r_r2     <= use2 ? c2 : '0;
            r_sat    <= (use1 && k1) || (use2 && k2);
        end
    end

    assign o_root.valid       = r_ov;
    assign o_root.root_status = r_status;
    assign o_root.root_one    = r_r1;
    assign o_root.root_two    = r_r2;
    assign o_root.saturated   = r_sat;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q1_v == q2_v) else $error("divider lanes out of step");
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && (r_status == qes_pkg::ST_INFINITE || r_status == qes_pkg::ST_NONE)
        |-> r_r1 == '0 && r_r2 == '0 && !r_sat) else $error("unused roots not cleared");
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_status != qes_pkg::ST_TWO |-> r_r2 == '0)
        else $error("second root set without two roots");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_pv) && $stable(r_dvs)) else $error("pipeline moved in stall");
endmodule

// ===== rtl/core/qes_disc.sv =====
// Two-stage discriminant b*b - 4*a*c with coefficient pass-through.
// Standalone, no package use.
module qes_disc #(
    parameter int CW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [CW-1:0]       i_a,
    input  logic [CW-1:0]       i_b,
    input  logic [CW-1:0]       i_c,
    output logic                o_valid,
    output logic [2*CW+1:0]     o_d,
    output logic [CW-1:0]       o_a,
    output logic [CW-1:0]       o_b,
    output logic [CW-1:0]       o_c,
    output logic                o_dneg,
    output logic                o_dzero
);
    localparam int DW = 2*CW+2;

    logic                 r_v1, r_v2;
    logic [CW-1:0]        r_a1, r_b1, r_c1, r_a2, r_b2, r_c2;
    logic signed [2*CW-1:0] r_bb, r_ac;
    logic signed [DW-1:0] r_d;
    logic signed [DW-1:0] n_d;

    assign n_d = $signed({{2{r_bb[2*CW-1]}}, r_bb}) - $signed({r_ac, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_a1 <= i_a;
            r_b1 <= i_b;
            r_c1 <= i_c;
            r_bb <= $signed(i_b) * $signed(i_b);
            r_ac <= $signed(i_a) * $signed(i_c);
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_c2 <= r_c1;
            r_d  <= n_d;
        end
    end

    assign o_valid = r_v2;
    assign o_dneg  = r_d[DW-1];
    assign o_dzero = (r_d == '0);
    assign o_d     = o_dneg ? '0 : r_d;
    assign o_a     = r_a2;
    assign o_b     = r_b2;
    assign o_c     = r_c2;
endmodule

// ===== rtl/core/qes_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
// Standalone, no package use.
module qes_sqrt #(
    parameter int SW  = 17,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*SW-1:0] i_x,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [SW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);
    localparam int RMW = SW+3;

    logic            r_v    [SW];
    logic [2*SW-1:0] r_x    [SW];
    logic [RMW-1:0]  r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [SBW-1:0]  r_sb   [SW];
    logic            n_v    [SW];
    logic [2*SW-1:0] n_x    [SW];
    logic [RMW-1:0]  n_rem  [SW];
    logic [SW-1:0]   n_root [SW];
    logic [SBW-1:0]  n_sb   [SW];

    always_comb begin
        logic [2*SW-1:0] px;
        logic [RMW-1:0]  prem, rem2, trial;
        logic [SW-1:0]   proot;
        for (int k = 0; k < SW; k++) begin
            if (k == 0) begin
                px = i_x; prem = '0; proot = '0;
                n_v[k] = i_valid; n_sb[k] = i_sb;
            end else begin
                px = r_x[k-1]; prem = r_rem[k-1]; proot = r_root[k-1];
                n_v[k] = r_v[k-1]; n_sb[k] = r_sb[k-1];
            end
            rem2  = {prem[RMW-3:0], px[2*SW-1:2*SW-2]};
            trial = {1'b0, proot, 2'b01};
            n_x[k] = px << 2;
            if (rem2 >= trial) begin
                n_rem[k]  = rem2 - trial;
                n_root[k] = {proot[SW-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem2;
                n_root[k] = {proot[SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SW; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= n_v[k];
            end
            if (i_en) begin
                r_x[k]    <= n_x[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_sb[k]   <= n_sb[k];
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_sb    = r_sb[SW-1];
endmodule

// ===== rtl/core/qes_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone, no package use.
module qes_div #(
    parameter int DVW = 33,
    parameter int DSW = 17,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [DVW-1:0] i_dvd,
    input  logic [DSW-1:0] i_dvs,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [DVW-1:0] o_quot,
    output logic [SBW-1:0] o_sb
);
    logic           r_v   [DVW];
    logic [DVW-1:0] r_q   [DVW];
    logic [DSW-1:0] r_rem [DVW];
    logic [DSW-1:0] r_dvs [DVW];
    logic [SBW-1:0] r_sb  [DVW];
    logic           n_v   [DVW];
    logic [DVW-1:0] n_q   [DVW];
    logic [DSW-1:0] n_rem [DVW];
    logic [DSW-1:0] n_dvs [DVW];
    logic [SBW-1:0] n_sb  [DVW];

    always_comb begin
        logic [DVW-1:0] pq;
        logic [DSW-1:0] prem;
        logic [DSW:0]   rem2, diff;
        logic           ge;
        for (int k = 0; k < DVW; k++) begin
            if (k == 0) begin
                pq = i_dvd; prem = '0; n_dvs[k] = i_dvs;
                n_v[k] = i_valid; n_sb[k] = i_sb;
            end else begin
                pq = r_q[k-1]; prem = r_rem[k-1]; n_dvs[k] = r_dvs[k-1];
                n_v[k] = r_v[k-1]; n_sb[k] = r_sb[k-1];
            end
            rem2 = {prem, pq[DVW-1]};
            diff = rem2 - {1'b0, n_dvs[k]};
            ge   = (rem2 >= {1'b0, n_dvs[k]});
            n_rem[k] = ge ? diff[DSW-1:0] : rem2[DSW-1:0];
            n_q[k]   = {pq[DVW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DVW; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= n_v[k];
            end
            if (i_en) begin
                r_q[k]   <= n_q[k];
                r_rem[k] <= n_rem[k];
                r_dvs[k] <= n_dvs[k];
                r_sb[k]  <= n_sb[k];
            end
        end
    end

    assign o_valid = r_v[DVW-1];
    assign o_quot  = r_q[DVW-1];
    assign o_sb    = r_sb[DVW-1];
endmodule
